// ===== src/cnfsa_pkg.sv =====
// Package for the circular next-free slot allocator.
// Holds field widths, command and status codes shared by the interfaces and the top level.
// No dependencies.
`timescale 1ns / 1ps

package cnfsa_pkg;

    localparam int CMD_W    = 1;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 3;

    // Largest slot count reachable through an 8-bit index
    localparam int INDEX_SPAN = 1 << INDEX_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM   = 1'b0,
        CMD_RELEASE = 1'b1
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLAIMED      = 3'd0,
        ST_RELEASED     = 3'd1,
        ST_FREE_RELEASE = 3'd2,
        ST_FULL         = 3'd3,
        ST_RANGE        = 3'd4
    } t_status;

endpackage

// ===== src/cnfsa_if.sv =====
// Request and response channel interfaces for the slot allocator.
// Depends on cnfsa_pkg for field widths and status codes.
`timescale 1ns / 1ps

interface cnfsa_req_if
    import cnfsa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [INDEX_W-1:0]   slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface

interface cnfsa_rsp_if
    import cnfsa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   granted_slot;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output granted_slot, output status, input ready);
    modport sink   (input valid, input granted_slot, input status, output ready);
endinterface

// ===== src/circular_next_free_slot_allocator.sv =====
// Top level of the circular next-free slot allocator: occupancy bitmap and search.
// Depends on cnfsa_pkg and the channel interfaces in cnfsa_if.sv.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    command, slot_index
//   o_rsp     out  valid/ready    granted_slot, status
//   cfg       in   i_cfg_we       i_cfg_wdata (slot_count)
//
// One transaction per cycle while the response is not stalled; each request gives one
// response, held first in the request register, then in the response register.
// The rate is set by the read-modify-write of the occupancy bitmap,
// done by a circular priority encoder between the request and response registers.
// Reset clears the bitmap and sets slot_count to 256; no clearing pass is needed.
// A stalled response holds the pipeline; the request register still refills when
// the response register drains in the same cycle.
`timescale 1ns / 1ps

module circular_next_free_slot_allocator
    import cnfsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    cnfsa_req_if.sink          i_req,
    cnfsa_rsp_if.source        o_rsp
);

    localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAP = (SLOTS < INDEX_SPAN) ? SLOTS : INDEX_SPAN;

    logic [COUNT_W-1:0]  r_slot_count;
    logic [SLOTS-1:0]    r_occ;
    logic [SLOTS-1:0]    n_occ;

    logic                r_req_valid;
    logic [CMD_W-1:0]    r_req_cmd;
    logic [INDEX_W-1:0]  r_req_idx;

    logic                r_rsp_valid;
    logic [INDEX_W-1:0]  r_rsp_slot;
    logic [STATUS_W-1:0] r_rsp_status;
    logic [INDEX_W-1:0]  n_rsp_slot;
    t_status             n_rsp_status;

    logic                advance;
    logic [COUNT_W-1:0]  eff_count;
    logic [SLOTS-1:0]    in_range;
    logic [SLOTS-1:0]    at_or_above;
    logic [SLOTS-1:0]    at_idx;
    logic [SLOTS-1:0]    free_vec;
    logic [SLOTS-1:0]    search_vec;
    logic [SLOTS-1:0]    pick_onehot;
    logic [IW-1:0]       pick;

    // Move the pipeline when the response register is empty or being taken
    assign advance     = !r_rsp_valid || o_rsp.ready;
    assign i_req.ready = !r_req_valid || advance;

    // Clamp the configured count to 1..min(SLOTS, index span)
    always_comb begin
        if (r_slot_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (32'(r_slot_count) > CAP) begin
            eff_count = COUNT_W'(CAP);
        end else begin
            eff_count = r_slot_count;
        end
    end

    // Per-slot masks relative to the requested index and the slot count
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            in_range[i]    = (i < 32'(eff_count));
            at_or_above[i] = (i >= 32'(r_req_idx));
            at_idx[i]      = (i == 32'(r_req_idx));
        end
    end

    // Search from the requested slot upward, else wrap to the bottom
    always_comb begin
        free_vec    = ~r_occ & in_range;
        search_vec  = ((free_vec & at_or_above) != '0) ? (free_vec & at_or_above) : free_vec;
        pick_onehot = search_vec & (~search_vec + SLOTS'(1));
        pick        = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (pick_onehot[i]) begin
                pick = pick | IW'(i);
            end
        end
    end

    // Decide the response and the bitmap update for the held request
    always_comb begin
        n_occ        = r_occ;
        n_rsp_slot   = '0;
        n_rsp_status = ST_RANGE;
        if (32'(r_req_idx) >= 32'(eff_count)) begin
            n_rsp_status = ST_RANGE;
        end else if (r_req_cmd == CMD_CLAIM) begin
            if (free_vec == '0) begin
                n_rsp_status = ST_FULL;
            end else begin
                n_occ        = r_occ | pick_onehot;
                n_rsp_slot   = INDEX_W'(pick);
                n_rsp_status = ST_CLAIMED;
            end
        end else begin
            if ((r_occ & at_idx) != '0) begin
                n_occ        = r_occ & ~at_idx;
                n_rsp_status = ST_RELEASED;
            end else begin
                n_rsp_status = ST_FREE_RELEASE;
            end
        end
    end

    // Hold the slot count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= COUNT_W'(INDEX_SPAN);
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_wdata;
        end
    end

    // Capture accepted transactions into the request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_cmd <= i_req.command;
            r_req_idx <= i_req.slot_index;
        end
    end

    // Commit the bitmap and load the response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= r_req_valid;
            if (r_req_valid) begin
                r_occ <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_req_valid) begin
            r_rsp_slot   <= n_rsp_slot;
            r_rsp_status <= n_rsp_status;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.granted_slot = r_rsp_slot;
    assign o_rsp.status       = r_rsp_status;

endmodule
